// ----- sv/hotp_pkg.sv -----
// Shared types, constants and SHA-1 round helpers for the HOTP code generator.
`default_nettype none
package hotp_pkg;

   typedef struct packed {
      logic [31:0] a;
      logic [31:0] b;
      logic [31:0] c;
      logic [31:0] d;
      logic [31:0] e;
   } sha_st_type;

   typedef logic [15:0][31:0] sha_win_type;

   localparam int SIDE_W = 160;
   typedef logic [SIDE_W-1:0] side_type;

   localparam int NUM_ROUNDS = 80;
   localparam int NUM_KEYS   = 4;

   localparam int CODE_DIGITS = 6;
   localparam int CODE_W      = 20;
   localparam int WORD_W      = 31;
   localparam logic [WORD_W-1:0] CODE_MOD = WORD_W'(10 ** CODE_DIGITS);
   localparam int RECIP_SHIFT = WORD_W + $clog2(10 ** CODE_DIGITS);
   localparam logic [31:0] RECIP =
      32'(((64'd1 << RECIP_SHIFT) / (10 ** CODE_DIGITS)) + 64'd1);

   localparam sha_st_type SHA_IV = '{
      a: 32'h67452301, b: 32'hEFCDAB89, c: 32'h98BADCFE,
      d: 32'h10325476, e: 32'hC3D2E1F0
   };

   localparam logic [7:0] IPAD = 8'h36;
   localparam logic [7:0] OPAD = 8'h5C;
   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [63:0] INNER_LEN_BITS = 64'd576;
   localparam logic [63:0] OUTER_LEN_BITS = 64'd672;

   function automatic sha_win_type blk_to_win(input logic [511:0] blk);
      sha_win_type w;
      for (int j = 0; j < 16; j++) begin
         w[j] = blk[511-32*j -: 32];
      end
      return w;
   endfunction

   function automatic sha_st_type sha_round(input sha_st_type s, input logic [31:0] wi,
                                            input int idx);
      logic [31:0] f;
      logic [31:0] k;
      logic [31:0] t;
      sha_st_type  n;
      if (idx < 20) begin
         f = (s.b & s.c) | (~s.b & s.d);
         k = 32'h5A827999;
      end else if (idx < 40) begin
         f = s.b ^ s.c ^ s.d;
         k = 32'h6ED9EBA1;
      end else if (idx < 60) begin
         f = (s.b & s.c) | (s.b & s.d) | (s.c & s.d);
         k = 32'h8F1BBCDC;
      end else begin
         f = s.b ^ s.c ^ s.d;
         k = 32'hCA62C1D6;
      end
      t = {s.a[26:0], s.a[31:27]} + f + s.e + k + wi;
      n.a = t;
      n.b = s.a;
      n.c = {s.b[1:0], s.b[31:2]};
      n.d = s.c;
      n.e = s.d;
      return n;
   endfunction

   function automatic sha_win_type win_next(input sha_win_type w);
      logic [31:0] x;
      x = w[13] ^ w[8] ^ w[2] ^ w[0];
      return {{x[30:0], x[31]}, w[15:1]};
   endfunction

endpackage
`default_nettype wire

// ----- sv/hotp_blk.sv -----
// One SHA-1 block compression, one round per pipeline stage plus a final add stage.
`default_nettype none
module hotp_blk (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   en,
   input  wire                   in_vld,
   input  hotp_pkg::sha_st_type  in_h,
   input  wire  [511:0]          in_blk,
   input  hotp_pkg::side_type    in_side,
   output logic                  out_vld,
   output hotp_pkg::sha_st_type  out_h,
   output hotp_pkg::side_type    out_side
);
   import hotp_pkg::*;

   logic        vld_ff  [NUM_ROUNDS];
   sha_st_type  st_ff   [NUM_ROUNDS];
   sha_win_type w_ff    [NUM_ROUNDS];
   sha_st_type  h_ff    [NUM_ROUNDS];
   side_type    side_ff [NUM_ROUNDS];

   logic        fin_vld_ff;
   sha_st_type  fin_h_ff;
   side_type    fin_side_ff;

   for (genvar i = 0; i < NUM_ROUNDS; i++) begin : g_rnd
      logic        src_vld;
      sha_st_type  src_st;
      sha_win_type src_w;
      sha_st_type  src_h;
      side_type    src_side;
      sha_st_type  st_in;
      sha_win_type w_in;

      if (i == 0) begin : g_first
         assign src_vld  = in_vld;
         assign src_st   = in_h;
         assign src_w    = blk_to_win(in_blk);
         assign src_h    = in_h;
         assign src_side = in_side;
      end else begin : g_next
         assign src_vld  = vld_ff[i-1];
         assign src_st   = st_ff[i-1];
         assign src_w    = w_ff[i-1];
         assign src_h    = h_ff[i-1];
         assign src_side = side_ff[i-1];
      end

      assign st_in = sha_round(src_st, src_w[0], i);
      assign w_in  = win_next(src_w);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (en) begin
            vld_ff[i] <= src_vld;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            st_ff[i]   <= st_in;
            w_ff[i]    <= w_in;
            h_ff[i]    <= src_h;
            side_ff[i] <= src_side;
         end
      end
   end

   sha_st_type fin_h_in;
   sha_st_type last_st;
   sha_st_type last_h;

   assign last_st = st_ff[NUM_ROUNDS-1];
   assign last_h  = h_ff[NUM_ROUNDS-1];
   assign fin_h_in.a = last_h.a + last_st.a;
   assign fin_h_in.b = last_h.b + last_st.b;
   assign fin_h_in.c = last_h.c + last_st.c;
   assign fin_h_in.d = last_h.d + last_st.d;
   assign fin_h_in.e = last_h.e + last_st.e;

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
      end else if (en) begin
         fin_vld_ff <= vld_ff[NUM_ROUNDS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         fin_h_ff    <= fin_h_in;
         fin_side_ff <= side_ff[NUM_ROUNDS-1];
      end
   end

   assign out_vld  = fin_vld_ff;
   assign out_h    = fin_h_ff;
   assign out_side = fin_side_ff;

endmodule
`default_nettype wire

// ----- sv/hotp_sha1_code_generator_core.sv -----
// HOTP six-digit code generator top level: key registers, four SHA-1 blocks, truncation.
//
// Takes one 64-bit counter per cycle while req_tready is high and returns one code per
// counter, in order. Each beat passes four SHA-1 block pipelines of 81 stages each (80
// rounds and a final add: inner key block, inner counter block, outer key block, outer
// digest block), three stages of truncation and reduction and the output register. A
// two-deep output register takes one more beat while a result waits; beyond that,
// req_tready drops until rsp_tready returns. The key is read from csr registers at each
// key block entry, so it must only change while no beat is in flight.
`default_nettype none
module hotp_sha1_code_generator_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [63:0] req_tdata,   // [63:0] counter_value
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [23:0] rsp_tdata,   // [19:0] code_value, [23:20] zero
   input  wire         csr_we,
   input  wire  [1:0]  csr_index,
   input  wire  [63:0] csr_wdata
);
   import hotp_pkg::*;

   logic [63:0] key_ff [NUM_KEYS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_KEYS; i++) begin
            key_ff[i] <= 64'd0;
         end
      end else if (csr_we) begin
         key_ff[csr_index] <= csr_wdata;
      end
   end

   logic [511:0] key_blk;
   assign key_blk = {key_ff[0], key_ff[1], key_ff[2], key_ff[3], 256'd0};

   logic en;
   logic skid_vld_ff;
   assign en = ~skid_vld_ff;
   assign req_tready = en;

   // inner key block
   logic       i1_vld;
   sha_st_type i1_h;
   side_type   i1_side;

   hotp_blk u_inner_key (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (req_tvalid),
      .in_h     (SHA_IV),
      .in_blk   (key_blk ^ {64{IPAD}}),
      .in_side  (side_type'(req_tdata)),
      .out_vld  (i1_vld),
      .out_h    (i1_h),
      .out_side (i1_side)
   );

   // inner counter block
   logic       i2_vld;
   sha_st_type i2_h;
   side_type   i2_side;

   hotp_blk u_inner_msg (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (i1_vld),
      .in_h     (i1_h),
      .in_blk   ({i1_side[63:0], PAD_MARK, 376'd0, INNER_LEN_BITS}),
      .in_side  ('0),
      .out_vld  (i2_vld),
      .out_h    (i2_h),
      .out_side (i2_side)
   );

   // outer key block, inner digest carried alongside
   logic       o1_vld;
   sha_st_type o1_h;
   side_type   o1_side;

   hotp_blk u_outer_key (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (i2_vld),
      .in_h     (SHA_IV),
      .in_blk   (key_blk ^ {64{OPAD}}),
      .in_side  (side_type'(i2_h)),
      .out_vld  (o1_vld),
      .out_h    (o1_h),
      .out_side (o1_side)
   );

   logic       o2_vld;
   sha_st_type o2_h;
   side_type   o2_side;

   hotp_blk u_outer_msg (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (o1_vld),
      .in_h     (o1_h),
      .in_blk   ({o1_side, PAD_MARK, 280'd0, OUTER_LEN_BITS}),
      .in_side  (i2_side),
      .out_vld  (o2_vld),
      .out_h    (o2_h),
      .out_side (o2_side)
   );

   // dynamic truncation
   logic [159:0]      digest;
   logic [3:0]        off;
   logic [7:0]        sh;
   logic [159:0]      shifted;
   logic [WORD_W-1:0] word_in;

   assign digest  = o2_h;
   assign off     = digest[3:0];
   assign sh      = 8'd128 - {1'b0, off, 3'b000};
   assign shifted = digest >> sh;
   assign word_in = shifted[WORD_W-1:0];

   logic              t1_vld_ff;
   logic [WORD_W-1:0] t1_word_ff;
   logic              t2_vld_ff;
   logic [WORD_W-1:0] t2_word_ff;
   logic [62:0]       t2_prod_ff;
   logic [62:0]       t2_prod_in;
   logic              t3_vld_ff;
   logic [CODE_W-1:0] t3_code_ff;
   logic [WORD_W-1:0] quo;
   logic [WORD_W-1:0] rem;

   assign t2_prod_in = 63'(t1_word_ff) * 63'(RECIP);
   assign quo        = WORD_W'(t2_prod_ff >> RECIP_SHIFT);
   assign rem        = t2_word_ff - WORD_W'(62'(quo) * 62'(CODE_MOD));

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_vld_ff <= 1'b0;
         t2_vld_ff <= 1'b0;
         t3_vld_ff <= 1'b0;
      end else if (en) begin
         t1_vld_ff <= o2_vld;
         t2_vld_ff <= t1_vld_ff;
         t3_vld_ff <= t2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         t1_word_ff <= word_in;
         t2_word_ff <= t1_word_ff;
         t2_prod_ff <= t2_prod_in;
         t3_code_ff <= rem[CODE_W-1:0];
      end
   end

   // output register with skid stage
   logic              out_vld_ff;
   logic [CODE_W-1:0] out_code_ff;
   logic [CODE_W-1:0] skid_code_ff;
   logic              tail_vld;

   assign tail_vld = en & t3_vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (out_vld_ff & rsp_tready) begin
         if (skid_vld_ff) begin
            skid_vld_ff <= 1'b0;
         end else begin
            out_vld_ff <= tail_vld;
         end
      end else if (!out_vld_ff) begin
         out_vld_ff <= tail_vld;
      end else if (tail_vld) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_vld_ff & rsp_tready) begin
         out_code_ff <= skid_vld_ff ? skid_code_ff : t3_code_ff;
      end else if (!out_vld_ff) begin
         out_code_ff <= t3_code_ff;
      end else if (tail_vld) begin
         skid_code_ff <= t3_code_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {4'd0, out_code_ff};

endmodule
`default_nettype wire
